### src/bst_pkg.sv
// ----------------------------------------------------------------------------
// Binned threshold scale table package
// Shared types, sizes and operation codes for the threshold table unit.
// ----------------------------------------------------------------------------
package bst_pkg;

	// Table geometry
	localparam int RANK_BINS = 256;
	localparam int ETA_BINS  = 32;

	localparam int RANK_AW   = (RANK_BINS > 1) ? $clog2(RANK_BINS) : 1;
	localparam int ETA_AW    = (ETA_BINS > 1) ? $clog2(ETA_BINS) : 1;
	localparam int MEM_AW    = RANK_AW + ETA_AW;
	localparam int MEM_DEPTH = 1 << MEM_AW;

	// Field widths
	localparam int OP_W     = 2;
	localparam int RANK_W   = 8;
	localparam int ETA_W    = 5;
	localparam int ENERGY_W = 16;
	localparam int STEP_W   = 12;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(8);

	typedef enum logic [OP_W-1:0] {
		OP_FILL  = 2'd0,
		OP_WRITE = 2'd1,
		OP_QUANT = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [RANK_W-1:0]   rank_index;
		logic [ETA_W-1:0]    eta_index;
		logic [ENERGY_W-1:0] energy_value;
	} in_item_t;

	typedef struct packed {
		logic [RANK_W-1:0]   rank_result;
		logic [ENERGY_W-1:0] energy_result;
		logic                index_error;
	} out_item_t;

	typedef struct packed {
		logic                we;
		logic                re;
		logic [MEM_AW-1:0]   addr;
		logic [ENERGY_W-1:0] wdata;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_SCAN,
		ST_TAIL
	} state_t;

endpackage

### src/bst_ram.sv
// ----------------------------------------------------------------------------
// Threshold table memory
// Single-port synchronous RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module bst_ram (
	input  logic                         clk,
	input  bst_pkg::mem_req_t            req,
	output logic [bst_pkg::ENERGY_W-1:0] rdata
);

	logic [bst_pkg::ENERGY_W-1:0] mem [bst_pkg::MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

### src/bst_seq.sv
// ----------------------------------------------------------------------------
// Threshold table sequencer
// Runs fill sweeps, single writes and reads, and the per-eta quantize scan.
// ----------------------------------------------------------------------------
module bst_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  bst_pkg::in_item_t            cmd,
	input  logic [bst_pkg::STEP_W-1:0]   linear_step,
	input  logic [bst_pkg::ENERGY_W-1:0] rdata,
	output bst_pkg::mem_req_t            req,
	output logic                         busy,
	output logic                         done,
	output bst_pkg::out_item_t           result
);

	localparam logic [bst_pkg::RANK_AW-1:0] RANK_LAST = bst_pkg::RANK_AW'(bst_pkg::RANK_BINS - 1);
	localparam logic [bst_pkg::ETA_AW-1:0]  ETA_LAST  = bst_pkg::ETA_AW'(bst_pkg::ETA_BINS - 1);

	bst_pkg::state_t state_q, state_nxt;

	logic [bst_pkg::RANK_AW-1:0]  rank_q;
	logic [bst_pkg::ETA_AW-1:0]   eta_q;
	logic [bst_pkg::ENERGY_W-1:0] acc_q;
	logic [bst_pkg::ENERGY_W-1:0] energy_q;
	logic [bst_pkg::RANK_AW-1:0]  best_q;
	logic [bst_pkg::RANK_AW-1:0]  rank_s1;
	logic                         vld_s1;
	logic                         done_q;
	bst_pkg::out_item_t           result_q;

	logic                         accept;
	logic                         rank_ok, eta_ok;
	logic [bst_pkg::MEM_AW-1:0]   in_addr;
	logic                         fill_last;
	logic                         hit;
	logic [bst_pkg::RANK_AW-1:0]  best_final;
	logic [bst_pkg::ENERGY_W:0]   acc_sum;
	logic [bst_pkg::ENERGY_W-1:0] acc_next;
	logic                         finish;
	bst_pkg::out_item_t           fin;

	assign accept    = start && (state_q == bst_pkg::ST_IDLE);
	assign busy      = (state_q != bst_pkg::ST_IDLE);
	assign rank_ok   = {1'b0, cmd.rank_index} < (bst_pkg::RANK_W + 1)'(bst_pkg::RANK_BINS);
	assign eta_ok    = {1'b0, cmd.eta_index} < (bst_pkg::ETA_W + 1)'(bst_pkg::ETA_BINS);
	assign in_addr   = {cmd.rank_index[bst_pkg::RANK_AW-1:0], cmd.eta_index[bst_pkg::ETA_AW-1:0]};
	assign fill_last = (rank_q == RANK_LAST) && (eta_q == ETA_LAST);

	// threshold met by the energy being quantized
	assign hit        = vld_s1 && (energy_q >= rdata);
	assign best_final = hit ? rank_s1 : best_q;

	// saturating step accumulator for the linear fill
	assign acc_sum  = {1'b0, acc_q} + (bst_pkg::ENERGY_W + 1)'(linear_step);
	assign acc_next = acc_sum[bst_pkg::ENERGY_W] ? '1 : acc_sum[bst_pkg::ENERGY_W-1:0];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bst_pkg::ST_IDLE: begin
				if (start) begin
					case (bst_pkg::op_t'(cmd.op))
						bst_pkg::OP_FILL:  state_nxt = bst_pkg::ST_FILL;
						bst_pkg::OP_QUANT: state_nxt = eta_ok ? bst_pkg::ST_SCAN : bst_pkg::ST_IDLE;
						bst_pkg::OP_READ: begin
							state_nxt = (rank_ok && eta_ok) ? bst_pkg::ST_READ : bst_pkg::ST_IDLE;
						end
						default:           state_nxt = bst_pkg::ST_IDLE;
					endcase
				end
			end
			bst_pkg::ST_FILL: begin
				if (fill_last) state_nxt = bst_pkg::ST_IDLE;
			end
			bst_pkg::ST_SCAN: begin
				if (rank_q == RANK_LAST) state_nxt = bst_pkg::ST_TAIL;
			end
			bst_pkg::ST_TAIL: state_nxt = bst_pkg::ST_IDLE;
			bst_pkg::ST_READ: state_nxt = bst_pkg::ST_IDLE;
			default:          state_nxt = bst_pkg::ST_IDLE;
		endcase
	end

	// memory requests and completion
	always_comb begin
		req    = '0;
		finish = 1'b0;
		fin    = '0;
		case (state_q)
			bst_pkg::ST_IDLE: begin
				if (start) begin
					case (bst_pkg::op_t'(cmd.op))
						bst_pkg::OP_WRITE: begin
							req.we          = rank_ok && eta_ok;
							req.addr        = in_addr;
							req.wdata       = cmd.energy_value;
							finish          = 1'b1;
							fin.index_error = !(rank_ok && eta_ok);
						end
						bst_pkg::OP_QUANT: begin
							finish          = !eta_ok;
							fin.index_error = !eta_ok;
						end
						bst_pkg::OP_READ: begin
							req.re          = rank_ok && eta_ok;
							req.addr        = in_addr;
							finish          = !(rank_ok && eta_ok);
							fin.index_error = !(rank_ok && eta_ok);
						end
						default: ;
					endcase
				end
			end
			bst_pkg::ST_FILL: begin
				req.we    = 1'b1;
				req.addr  = {rank_q, eta_q};
				req.wdata = acc_q;
				finish    = fill_last;
			end
			bst_pkg::ST_SCAN: begin
				req.re   = 1'b1;
				req.addr = {rank_q, eta_q};
			end
			bst_pkg::ST_TAIL: begin
				finish          = 1'b1;
				fin.rank_result = bst_pkg::RANK_W'(best_final);
			end
			bst_pkg::ST_READ: begin
				finish            = 1'b1;
				fin.energy_result = rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bst_pkg::ST_IDLE;
			done_q  <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= finish;
			vld_s1  <= (state_q == bst_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= fin;
		end
		rank_s1 <= rank_q;
		if (accept) begin
			rank_q   <= '0;
			eta_q    <= cmd.eta_index[bst_pkg::ETA_AW-1:0];
			acc_q    <= '0;
			energy_q <= cmd.energy_value;
			best_q   <= '0;
			if (bst_pkg::op_t'(cmd.op) == bst_pkg::OP_FILL) begin
				eta_q <= '0;
			end
		end else if (state_q == bst_pkg::ST_FILL) begin
			// eta is the inner loop, one entry per cycle
			if (eta_q == ETA_LAST) begin
				eta_q  <= '0;
				rank_q <= rank_q + 1'b1;
				acc_q  <= acc_next;
			end else begin
				eta_q <= eta_q + 1'b1;
			end
		end else if (state_q == bst_pkg::ST_SCAN || state_q == bst_pkg::ST_TAIL) begin
			if (state_q == bst_pkg::ST_SCAN && rank_q != RANK_LAST) begin
				rank_q <= rank_q + 1'b1;
			end
			best_q <= best_final;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### src/binned_threshold_scale_table_unit.sv
// ----------------------------------------------------------------------------
// Binned threshold scale table unit
// Rank-by-eta table of energy thresholds with fill, write, read and quantize.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, in the cycle after the work ends,
// and cannot be held off by the receiver. The table sits in one single-port
// RAM, so accesses go one at a time: a write answers in the cycle after accept,
// a read after the read request and the registered RAM output, a quantize after
// the scan state (one read per rank for the eta bin) and the tail state, and a
// linear fill after every entry is written (one entry written per cycle). Entries
// are undefined after reset until a fill or a write covers them. linear_step is
// picked up rank by rank during a fill, so write it only while busy is low.
module binned_threshold_scale_table_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bst_pkg::in_item_t          cmd,
	output logic                       done,
	output bst_pkg::out_item_t         result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bst_pkg::STEP_W-1:0] cfg_data
);

	logic [bst_pkg::STEP_W-1:0]   step_q;
	bst_pkg::mem_req_t            req;
	logic [bst_pkg::ENERGY_W-1:0] rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bst_pkg::STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_data;
		end
	end

	bst_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.linear_step (step_q),
		.rdata       (rdata),
		.req         (req),
		.busy        (busy),
		.done        (done),
		.result      (result)
	);

	bst_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule
